>>> hdl/llpr_pkg.sv
// Shared types, codes and constants of the lidar label projection raster.
`timescale 1ns / 1ps
package llpr_pkg;

   // Default geometry of the label raster and the dilation window.
   localparam int DEF_RASTER_COLS   = 1024;
   localparam int DEF_RASTER_ROWS   = 512;
   localparam int DEF_DILATE_RADIUS = 3;

   // Quotient bits produced by the restoring divider.
   localparam int DIV_STEPS = 64;

   // Operation codes of the input transaction; code three reads as well.
   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;
   localparam logic [1:0] OP_READ_ALT = 2'd3;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_WRITTEN   = 3'd0,
      STATUS_REJ_CLASS = 3'd1,
      STATUS_REJ_NEAR  = 3'd2,
      STATUS_REJ_OFF   = 3'd3,
      STATUS_READ      = 3'd4,
      STATUS_CLEARED   = 3'd5
   } status_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_ROT_ROW0  = 3'd0,
      CSR_ROT_ROW1  = 3'd1,
      CSR_ROT_ROW2  = 3'd2,
      CSR_TRANS     = 3'd3,
      CSR_FOCAL     = 3'd4,
      CSR_PRINCIPAL = 3'd5,
      CSR_CLASS_A   = 3'd6,
      CSR_CLASS_B   = 3'd7
   } csr_index_type;

   // Configuration reset values: identity pose, fx = fy = 700, cx = 512, cy = 256.
   localparam logic [53:0] RST_ROT_ROW0  = 54'd65536;
   localparam logic [53:0] RST_ROT_ROW1  = 54'd17179869184;
   localparam logic [53:0] RST_ROT_ROW2  = 54'd4503599627370496;
   localparam logic [59:0] RST_TRANS     = 60'd0;
   localparam logic [47:0] RST_FOCAL     = 48'd48103636582400;
   localparam logic [47:0] RST_PRINCIPAL = 48'd17592188141568;
   localparam logic [47:0] RST_CLASS_A   = 48'd206161051708;
   localparam logic [47:0] RST_CLASS_B   = 48'd347897593928;

   // Multiply sequence: nine rotation products, then eight projection partials.
   typedef enum logic [4:0] {
      STEP_AX0 = 5'd0,  STEP_AX1 = 5'd1,  STEP_AX2 = 5'd2,
      STEP_AY0 = 5'd3,  STEP_AY1 = 5'd4,  STEP_AY2 = 5'd5,
      STEP_AZ0 = 5'd6,  STEP_AZ1 = 5'd7,  STEP_AZ2 = 5'd8,
      STEP_NC0 = 5'd9,  STEP_NC1 = 5'd10, STEP_NC2 = 5'd11, STEP_NC3 = 5'd12,
      STEP_NR0 = 5'd13, STEP_NR1 = 5'd14, STEP_NR2 = 5'd15, STEP_NR3 = 5'd16
   } mul_step_type;

   // Input transaction payload.
   typedef struct packed {
      logic [1:0]         operation;
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic signed [23:0] point_z;
      logic [15:0]        class_label;
      logic [8:0]         pixel_row;
      logic [9:0]         pixel_col;
   } req_payload_type;

   // Result transaction payload.
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] label;
      logic [8:0]  out_row;
      logic [9:0]  out_col;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         clr_init;
      logic         clr_we;
      logic         mul_en;
      logic         acc_en;
      mul_step_type step;
      logic         div_load;
      logic         div_step;
      logic         div_finish;
      logic         div_row;
      logic         add_we;
      logic         win_init;
      logic         win_read;
      logic         rsp_load;
      status_type   rsp_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic class_ok;
      logic too_near;
      logic off_image;
      logic clr_last;
      logic win_last;
   } dp_status_type;

endpackage

>>> hdl/lidar_label_projection_raster_top.sv
// Top level of the lidar label projection raster.
`timescale 1ns / 1ps
// Projects lidar points into a pinhole camera and keeps a raster of class labels,
// RASTER_COLS x RASTER_ROWS entries of 16 bits in one RAM. One transaction is
// worked at a time. An add-point transaction that is written or rejected off
// the image runs 17 products through a shared 25 x 19 multiplier and then a
// one-bit-per-cycle restoring divider for each of the column and the row.
// A read steps through the (2*DILATE_RADIUS+1)^2 window positions, with one
// RAM read for each position inside the raster. A clear transaction sweeps the
// RAM one entry per cycle. After reset the same sweep of all entries
// (RASTER_COLS*RASTER_ROWS, 524288 by default) runs while req_stall stays high;
// configuration writes are taken throughout. A finished result waits in the
// output register while the next transaction is accepted.
module lidar_label_projection_raster_top
   import llpr_pkg::*;
#(
   parameter int RASTER_COLS   = DEF_RASTER_COLS,
   parameter int RASTER_ROWS   = DEF_RASTER_ROWS,
   parameter int DILATE_RADIUS = DEF_DILATE_RADIUS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [2:0]      csr_index,
   input  logic [59:0]     csr_data
);

   localparam int DEPTH  = RASTER_COLS * RASTER_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [15:0]       mem_wr_data, mem_rd_data;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   // Sequencer.
   llpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.operation),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic, configuration and raster addressing.
   llpr_datapath #(
      .RASTER_COLS   (RASTER_COLS),
      .RASTER_ROWS   (RASTER_ROWS),
      .DILATE_RADIUS (DILATE_RADIUS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Label raster.
   llpr_ram #(
      .DATA_W (16),
      .DEPTH  (DEPTH)
   ) u_raster (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

>>> hdl/llpr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module llpr_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/llpr_ctrl.sv
// Controller state machine that sequences clear, add-point and read operations.
`timescale 1ns / 1ps
module llpr_ctrl
   import llpr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_op,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_CHECK  = 12'b0000_0000_0100,
      S_MUL    = 12'b0000_0000_1000,
      S_ACC    = 12'b0000_0001_0000,
      S_NEAR   = 12'b0000_0010_0000,
      S_DLOAD  = 12'b0000_0100_0000,
      S_DIV    = 12'b0000_1000_0000,
      S_DEND   = 12'b0001_0000_0000,
      S_WRITE  = 12'b0010_0000_0000,
      S_WIN    = 12'b0100_0000_0000,
      S_DONE   = 12'b1000_0000_0000
   } state_type;

   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   state_type              state_ff, state_in;
   mul_step_type           step_ff, step_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   div_row_ff, div_row_in;
   logic                   from_op_ff, from_op_in;
   logic                   drain_ff, drain_in;
   status_type             result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Next-state and command logic.
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      div_cnt_in = div_cnt_ff;
      div_row_in = div_row_ff;
      from_op_in = from_op_ff;
      drain_in   = 1'b0;
      result_in  = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd        = '0;
      cmd.step   = step_ff;
      cmd.div_row = div_row_ff;
      cmd.rsp_status = result_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_op == OP_CLEAR) begin
                  cmd.clr_init = 1'b1;
                  from_op_in   = 1'b1;
                  state_in     = S_CLEAR;
               end else if (req_op == OP_ADD) begin
                  state_in = S_CHECK;
               end else begin
                  cmd.win_init = 1'b1;
                  state_in     = S_WIN;
               end
            end
         end
         S_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (status.clr_last) begin
               from_op_in = 1'b0;
               if (from_op_ff) begin
                  result_in = STATUS_CLEARED;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CHECK: begin
            if (!status.class_ok) begin
               result_in = STATUS_REJ_CLASS;
               state_in  = S_DONE;
            end else begin
               step_in  = STEP_AX0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            if (step_ff == STEP_AZ2) begin
               state_in = S_NEAR;
            end else if (step_ff == STEP_NR3) begin
               div_row_in = 1'b0;
               state_in   = S_DLOAD;
            end else begin
               step_in  = mul_step_type'(step_ff + 5'd1);
               state_in = S_MUL;
            end
         end
         S_NEAR: begin
            if (status.too_near) begin
               result_in = STATUS_REJ_NEAR;
               state_in  = S_DONE;
            end else begin
               step_in  = STEP_NC0;
               state_in = S_MUL;
            end
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_DEND;
            end
         end
         S_DEND: begin
            cmd.div_finish = 1'b1;
            if (div_row_ff) begin
               state_in = S_WRITE;
            end else begin
               div_row_in = 1'b1;
               state_in   = S_DLOAD;
            end
         end
         S_WRITE: begin
            if (status.off_image) begin
               result_in = STATUS_REJ_OFF;
            end else begin
               cmd.add_we = 1'b1;
               result_in  = STATUS_WRITTEN;
            end
            state_in = S_DONE;
         end
         S_WIN: begin
            // Issue window reads; the drain flag holds off the result until the last read lands.
            if (drain_ff) begin
               result_in = STATUS_READ;
               state_in  = S_DONE;
            end else begin
               cmd.win_read = 1'b1;
               drain_in     = status.win_last;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= STEP_AX0;
         div_cnt_ff   <= '0;
         div_row_ff   <= 1'b0;
         from_op_ff   <= 1'b0;
         drain_ff     <= 1'b0;
         result_ff    <= STATUS_WRITTEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         div_cnt_ff   <= div_cnt_in;
         div_row_ff   <= div_row_in;
         from_op_ff   <= from_op_in;
         drain_ff     <= drain_in;
         result_ff    <= result_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/llpr_datapath.sv
// Datapath: configuration, transform and projection arithmetic, divider, raster access.
`timescale 1ns / 1ps
module llpr_datapath
   import llpr_pkg::*;
#(
   parameter int RASTER_COLS   = DEF_RASTER_COLS,
   parameter int RASTER_ROWS   = DEF_RASTER_ROWS,
   parameter int DILATE_RADIUS = DEF_DILATE_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  req_payload_type       req_payload,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   input  logic [2:0]            csr_index,
   input  logic [59:0]           csr_data,
   output logic                  mem_wr_en,
   output logic [$clog2(RASTER_COLS*RASTER_ROWS)-1:0] mem_wr_addr,
   output logic [15:0]           mem_wr_data,
   output logic                  mem_rd_en,
   output logic [$clog2(RASTER_COLS*RASTER_ROWS)-1:0] mem_rd_addr,
   input  logic [15:0]           mem_rd_data
);

   localparam int DEPTH  = RASTER_COLS * RASTER_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(RASTER_COLS);
   localparam int ROW_W  = $clog2(RASTER_ROWS);
   localparam int SPAN   = 2 * DILATE_RADIUS + 1;
   localparam int WIN_W  = $clog2(SPAN + 1);
   localparam logic [ADDR_W-1:0] W_ADDR    = ADDR_W'(RASTER_COLS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [63:0] WIDTH_LIM  = 64'(RASTER_COLS);
   localparam logic [63:0] HEIGHT_LIM = 64'(RASTER_ROWS);

   // Configuration registers.
   logic [53:0] rot0_ff, rot1_ff, rot2_ff;
   logic [59:0] trans_ff;
   logic [47:0] focal_ff, principal_ff, class_a_ff, class_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff      <= RST_ROT_ROW0;
         rot1_ff      <= RST_ROT_ROW1;
         rot2_ff      <= RST_ROT_ROW2;
         trans_ff     <= RST_TRANS;
         focal_ff     <= RST_FOCAL;
         principal_ff <= RST_PRINCIPAL;
         class_a_ff   <= RST_CLASS_A;
         class_b_ff   <= RST_CLASS_B;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROT_ROW0:  rot0_ff      <= csr_data[53:0];
            CSR_ROT_ROW1:  rot1_ff      <= csr_data[53:0];
            CSR_ROT_ROW2:  rot2_ff      <= csr_data[53:0];
            CSR_TRANS:     trans_ff     <= csr_data;
            CSR_FOCAL:     focal_ff     <= csr_data[47:0];
            CSR_PRINCIPAL: principal_ff <= csr_data[47:0];
            CSR_CLASS_A:   class_a_ff   <= csr_data[47:0];
            CSR_CLASS_B:   class_b_ff   <= csr_data[47:0];
         endcase
      end
   end

   // Captured input transaction.
   req_payload_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // Class acceptance against the six configured ids.
   logic [15:0] cls;
   assign cls = req_ff.class_label;
   assign status.class_ok = (cls == class_a_ff[15:0])  || (cls == class_a_ff[31:16]) ||
                            (cls == class_a_ff[47:32]) || (cls == class_b_ff[15:0])  ||
                            (cls == class_b_ff[31:16]) || (cls == class_b_ff[47:32]);

   // Accumulators: camera coordinates in 2^-26 m and projection numerators.
   logic signed [43:0] ax_ff, ay_ff, az_ff;
   logic signed [61:0] ncol_ff, nrow_ff;
   logic signed [43:0] prod_ff, prod_in;
   logic signed [24:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [35:0] x_cam, y_cam, z_cam;
   logic signed [61:0] prod_ext, prod_sh;

   // Coordinates floored to 2^-18 m.
   assign x_cam = ax_ff[43:8];
   assign y_cam = ay_ff[43:8];
   assign z_cam = az_ff[43:8];

   // Operand selection for the shared 25 x 19 multiplier.
   always_comb begin
      case (cmd.step)
         STEP_AX0: begin mul_a = 25'(req_ff.point_x); mul_b = 19'($signed(rot0_ff[17:0]));  end
         STEP_AX1: begin mul_a = 25'(req_ff.point_y); mul_b = 19'($signed(rot0_ff[35:18])); end
         STEP_AX2: begin mul_a = 25'(req_ff.point_z); mul_b = 19'($signed(rot0_ff[53:36])); end
         STEP_AY0: begin mul_a = 25'(req_ff.point_x); mul_b = 19'($signed(rot1_ff[17:0]));  end
         STEP_AY1: begin mul_a = 25'(req_ff.point_y); mul_b = 19'($signed(rot1_ff[35:18])); end
         STEP_AY2: begin mul_a = 25'(req_ff.point_z); mul_b = 19'($signed(rot1_ff[53:36])); end
         STEP_AZ0: begin mul_a = 25'(req_ff.point_x); mul_b = 19'($signed(rot2_ff[17:0]));  end
         STEP_AZ1: begin mul_a = 25'(req_ff.point_y); mul_b = 19'($signed(rot2_ff[35:18])); end
         STEP_AZ2: begin mul_a = 25'(req_ff.point_z); mul_b = 19'($signed(rot2_ff[53:36])); end
         STEP_NC0: begin
            mul_a = $signed({1'b0, focal_ff[23:0]});
            mul_b = $signed({1'b0, x_cam[17:0]});
         end
         STEP_NC1: begin
            mul_a = $signed({1'b0, focal_ff[23:0]});
            mul_b = 19'($signed(x_cam[35:18]));
         end
         STEP_NC2: begin
            mul_a = $signed({1'b0, principal_ff[23:0]});
            mul_b = $signed({1'b0, z_cam[17:0]});
         end
         STEP_NC3: begin
            mul_a = $signed({1'b0, principal_ff[23:0]});
            mul_b = 19'($signed(z_cam[35:18]));
         end
         STEP_NR0: begin
            mul_a = $signed({1'b0, focal_ff[47:24]});
            mul_b = $signed({1'b0, y_cam[17:0]});
         end
         STEP_NR1: begin
            mul_a = $signed({1'b0, focal_ff[47:24]});
            mul_b = 19'($signed(y_cam[35:18]));
         end
         STEP_NR2: begin
            mul_a = $signed({1'b0, principal_ff[47:24]});
            mul_b = $signed({1'b0, z_cam[17:0]});
         end
         STEP_NR3: begin
            mul_a = $signed({1'b0, principal_ff[47:24]});
            mul_b = 19'($signed(z_cam[35:18]));
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = 62'(prod_ff);
   assign prod_sh  = prod_ext <<< 18;

   // Product register.
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Accumulation of each product into its target; translation seeds the camera axes.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff   <= 44'($signed(trans_ff[19:0]))  <<< 16;
         ay_ff   <= 44'($signed(trans_ff[39:20])) <<< 16;
         az_ff   <= 44'($signed(trans_ff[59:40])) <<< 16;
         ncol_ff <= '0;
         nrow_ff <= '0;
      end else if (cmd.acc_en) begin
         case (cmd.step)
            STEP_AX0, STEP_AX1, STEP_AX2: ax_ff <= ax_ff + prod_ff;
            STEP_AY0, STEP_AY1, STEP_AY2: ay_ff <= ay_ff + prod_ff;
            STEP_AZ0, STEP_AZ1, STEP_AZ2: az_ff <= az_ff + prod_ff;
            STEP_NC0, STEP_NC2:           ncol_ff <= ncol_ff + prod_ext;
            STEP_NC1, STEP_NC3:           ncol_ff <= ncol_ff + prod_sh;
            STEP_NR0, STEP_NR2:           nrow_ff <= nrow_ff + prod_ext;
            STEP_NR1, STEP_NR3:           nrow_ff <= nrow_ff + prod_sh;
            default: begin end
         endcase
      end
   end

   // Depth of half a meter or less is rejected.
   assign status.too_near = (az_ff <= 44'sd33554432);

   // Restoring divider: quotient = (2|n| + d) / (2d), with d = 4096 * Z.
   logic signed [61:0] div_num;
   logic [61:0]        div_mag;
   logic [63:0]        div_dividend;
   logic [47:0]        div_den;
   logic [63:0]        quot_ff;
   logic [47:0]        rem_ff;
   logic               neg_ff;
   logic [48:0]        trial, trial_diff;
   logic               trial_ge;
   logic               coord_ok;

   assign div_num      = cmd.div_row ? nrow_ff : ncol_ff;
   assign div_mag      = div_num[61] ? 62'(-div_num) : 62'(div_num);
   assign div_dividend = {1'b0, div_mag, 1'b0} + {17'b0, z_cam[34:0], 12'b0};
   assign div_den      = {z_cam[34:0], 13'b0};
   assign trial        = {rem_ff, quot_ff[63]};
   assign trial_diff   = trial - {1'b0, div_den};
   assign trial_ge     = (trial >= {1'b0, div_den});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quot_ff <= div_dividend;
         rem_ff  <= '0;
         neg_ff  <= div_num[61];
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[62:0], trial_ge};
         rem_ff  <= trial_ge ? trial_diff[47:0] : trial[47:0];
      end
   end

   // A negative quotient other than zero is off the image.
   assign coord_ok = (!neg_ff || (quot_ff == 64'd0)) &&
                     (quot_ff < (cmd.div_row ? HEIGHT_LIM : WIDTH_LIM));

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic             col_off_ff, row_off_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_finish) begin
         if (cmd.div_row) begin
            row_ff     <= quot_ff[ROW_W-1:0];
            row_off_ff <= !coord_ok;
         end else begin
            col_ff     <= quot_ff[COL_W-1:0];
            col_off_ff <= !coord_ok;
         end
      end
   end

   assign status.off_image = col_off_ff || row_off_ff;

   // Clearing sweep counter.
   logic [ADDR_W-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_init) begin
         clr_ff <= '0;
      end else if (cmd.clr_we) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign status.clr_last = (clr_ff == LAST_ADDR);

   // Raster write port: clear sweep or accepted point.
   assign mem_wr_en   = cmd.clr_we || cmd.add_we;
   assign mem_wr_addr = cmd.clr_we ? clr_ff :
                        (ADDR_W'(row_ff) * W_ADDR + ADDR_W'(col_ff));
   assign mem_wr_data = cmd.clr_we ? 16'd0 : cls;

   // Window walk in row-major order around the requested pixel.
   logic [WIN_W-1:0]   wy_ff, wx_ff;
   logic signed [13:0] win_y, win_x;
   logic               center_ok, in_bounds;
   logic               rd_pend_ff;
   logic [15:0]        lab_ff;

   assign win_y = 14'(req_ff.pixel_row) + 14'(wy_ff) - 14'(DILATE_RADIUS);
   assign win_x = 14'(req_ff.pixel_col) + 14'(wx_ff) - 14'(DILATE_RADIUS);
   assign center_ok = (13'(req_ff.pixel_row) < 13'(RASTER_ROWS)) &&
                      (13'(req_ff.pixel_col) < 13'(RASTER_COLS));
   assign in_bounds = center_ok && !win_y[13] && !win_x[13] &&
                      (win_y[12:0] < 13'(RASTER_ROWS)) &&
                      (win_x[12:0] < 13'(RASTER_COLS));
   assign status.win_last = (wy_ff == WIN_W'(SPAN - 1)) && (wx_ff == WIN_W'(SPAN - 1));

   assign mem_rd_en   = cmd.win_read && in_bounds;
   assign mem_rd_addr = ADDR_W'(win_y[12:0]) * W_ADDR + ADDR_W'(win_x[12:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         wy_ff      <= '0;
         wx_ff      <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= mem_rd_en;
         if (cmd.win_init) begin
            wy_ff <= '0;
            wx_ff <= '0;
         end else if (cmd.win_read) begin
            if (wx_ff == WIN_W'(SPAN - 1)) begin
               wx_ff <= '0;
               wy_ff <= wy_ff + 1'b1;
            end else begin
               wx_ff <= wx_ff + 1'b1;
            end
         end
      end
   end

   // Keep the last nonzero label seen in the window.
   always_ff @(posedge clock) begin
      if (cmd.win_init) begin
         lab_ff <= '0;
      end else if (rd_pend_ff && (mem_rd_data != 16'd0)) begin
         lab_ff <= mem_rd_data;
      end
   end

   // Result register.
   rsp_payload_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_status;
         case (cmd.rsp_status)
            STATUS_WRITTEN: begin
               rsp_ff.label   <= cls;
               rsp_ff.out_row <= 9'(row_ff);
               rsp_ff.out_col <= 10'(col_ff);
            end
            STATUS_READ: begin
               rsp_ff.label   <= lab_ff;
               rsp_ff.out_row <= req_ff.pixel_row;
               rsp_ff.out_col <= req_ff.pixel_col;
            end
            default: begin
               rsp_ff.label   <= '0;
               rsp_ff.out_row <= '0;
               rsp_ff.out_col <= '0;
            end
         endcase
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
